### sv/mcc_pkg.sv
`default_nettype none
package mcc_pkg;

    localparam int JOBQ_DEPTH = 2;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [2:0] MAX_SYMBOLS = 3'd6;
    localparam logic [2:0] LEN_SAT     = 3'd7;

    // one unit of work for the emitter: optional lead byte, symbols, optional space
    typedef struct packed {
        logic       has_lead;
        logic [7:0] lead;
        logic [2:0] len;
        logic [5:0] pat;
        logic       has_tail;
    } t_job;

    typedef struct packed {
        logic       found;
        logic [2:0] len;
        logic [5:0] pat;
    } t_code;

    typedef struct packed {
        logic       found;
        logic [7:0] ch;
    } t_dec;

    // pattern bit i is symbol i, dash = 1
    function automatic t_code encode_char(input logic [7:0] c);
        t_code r;
        r = '{1'b1, 3'd0, 6'b000000};
        unique case (c)
            "A": r = '{1'b1, 3'd2, 6'b000010};
            "B": r = '{1'b1, 3'd4, 6'b000001};
            "C": r = '{1'b1, 3'd4, 6'b000101};
            "D": r = '{1'b1, 3'd3, 6'b000001};
            "E": r = '{1'b1, 3'd1, 6'b000000};
            "F": r = '{1'b1, 3'd4, 6'b000100};
            "G": r = '{1'b1, 3'd3, 6'b000011};
            "H": r = '{1'b1, 3'd4, 6'b000000};
            "I": r = '{1'b1, 3'd2, 6'b000000};
            "J": r = '{1'b1, 3'd4, 6'b001110};
            "K": r = '{1'b1, 3'd3, 6'b000101};
            "L": r = '{1'b1, 3'd4, 6'b000010};
            "M": r = '{1'b1, 3'd2, 6'b000011};
            "N": r = '{1'b1, 3'd2, 6'b000001};
            "O": r = '{1'b1, 3'd3, 6'b000111};
            "P": r = '{1'b1, 3'd4, 6'b000110};
            "Q": r = '{1'b1, 3'd4, 6'b001011};
            "R": r = '{1'b1, 3'd3, 6'b000010};
            "S": r = '{1'b1, 3'd3, 6'b000000};
            "T": r = '{1'b1, 3'd1, 6'b000001};
            "U": r = '{1'b1, 3'd3, 6'b000100};
            "V": r = '{1'b1, 3'd4, 6'b001000};
            "W": r = '{1'b1, 3'd3, 6'b000110};
            "X": r = '{1'b1, 3'd4, 6'b001001};
            "Y": r = '{1'b1, 3'd4, 6'b001101};
            "Z": r = '{1'b1, 3'd4, 6'b000011};
            "0": r = '{1'b1, 3'd5, 6'b011111};
            "1": r = '{1'b1, 3'd5, 6'b011110};
            "2": r = '{1'b1, 3'd5, 6'b011100};
            "3": r = '{1'b1, 3'd5, 6'b011000};
            "4": r = '{1'b1, 3'd5, 6'b010000};
            "5": r = '{1'b1, 3'd5, 6'b000000};
            "6": r = '{1'b1, 3'd5, 6'b000001};
            "7": r = '{1'b1, 3'd5, 6'b000011};
            "8": r = '{1'b1, 3'd5, 6'b000111};
            "9": r = '{1'b1, 3'd5, 6'b001111};
            ".": r = '{1'b1, 3'd6, 6'b101010};
            ",": r = '{1'b1, 3'd6, 6'b110011};
            "?": r = '{1'b1, 3'd6, 6'b001100};
            "!": r = '{1'b1, 3'd6, 6'b110101};
            "-": r = '{1'b1, 3'd6, 6'b100001};
            "/": r = '{1'b1, 3'd5, 6'b001001};
            "@": r = '{1'b1, 3'd6, 6'b010110};
            8'h22: r = '{1'b1, 3'd6, 6'b010010};
            8'h27: r = '{1'b1, 3'd6, 6'b011110};
            default: r = '{1'b0, 3'd0, 6'b000000};
        endcase
        return r;
    endfunction

    function automatic t_dec decode_code(input logic [2:0] len, input logic [5:0] pat);
        t_dec r;
        r = '{1'b0, 8'h00};
        unique case ({len, pat})
            {3'd2, 6'b000010}: r = '{1'b1, "A"};
            {3'd4, 6'b000001}: r = '{1'b1, "B"};
            {3'd4, 6'b000101}: r = '{1'b1, "C"};
            {3'd3, 6'b000001}: r = '{1'b1, "D"};
            {3'd1, 6'b000000}: r = '{1'b1, "E"};
            {3'd4, 6'b000100}: r = '{1'b1, "F"};
            {3'd3, 6'b000011}: r = '{1'b1, "G"};
            {3'd4, 6'b000000}: r = '{1'b1, "H"};
            {3'd2, 6'b000000}: r = '{1'b1, "I"};
            {3'd4, 6'b001110}: r = '{1'b1, "J"};
            {3'd3, 6'b000101}: r = '{1'b1, "K"};
            {3'd4, 6'b000010}: r = '{1'b1, "L"};
            {3'd2, 6'b000011}: r = '{1'b1, "M"};
            {3'd2, 6'b000001}: r = '{1'b1, "N"};
            {3'd3, 6'b000111}: r = '{1'b1, "O"};
            {3'd4, 6'b000110}: r = '{1'b1, "P"};
            {3'd4, 6'b001011}: r = '{1'b1, "Q"};
            {3'd3, 6'b000010}: r = '{1'b1, "R"};
            {3'd3, 6'b000000}: r = '{1'b1, "S"};
            {3'd1, 6'b000001}: r = '{1'b1, "T"};
            {3'd3, 6'b000100}: r = '{1'b1, "U"};
            {3'd4, 6'b001000}: r = '{1'b1, "V"};
            {3'd3, 6'b000110}: r = '{1'b1, "W"};
            {3'd4, 6'b001001}: r = '{1'b1, "X"};
            {3'd4, 6'b001101}: r = '{1'b1, "Y"};
            {3'd4, 6'b000011}: r = '{1'b1, "Z"};
            {3'd5, 6'b011111}: r = '{1'b1, "0"};
            {3'd5, 6'b011110}: r = '{1'b1, "1"};
            {3'd5, 6'b011100}: r = '{1'b1, "2"};
            {3'd5, 6'b011000}: r = '{1'b1, "3"};
            {3'd5, 6'b010000}: r = '{1'b1, "4"};
            {3'd5, 6'b000000}: r = '{1'b1, "5"};
            {3'd5, 6'b000001}: r = '{1'b1, "6"};
            {3'd5, 6'b000011}: r = '{1'b1, "7"};
            {3'd5, 6'b000111}: r = '{1'b1, "8"};
            {3'd5, 6'b001111}: r = '{1'b1, "9"};
            {3'd6, 6'b101010}: r = '{1'b1, "."};
            {3'd6, 6'b110011}: r = '{1'b1, ","};
            {3'd6, 6'b001100}: r = '{1'b1, "?"};
            {3'd6, 6'b110101}: r = '{1'b1, "!"};
            {3'd6, 6'b100001}: r = '{1'b1, "-"};
            {3'd5, 6'b001001}: r = '{1'b1, "/"};
            {3'd6, 6'b010110}: r = '{1'b1, "@"};
            {3'd6, 6'b010010}: r = '{1'b1, 8'h22};
            {3'd6, 6'b011110}: r = '{1'b1, 8'h27};
            default: r = '{1'b0, 8'h00};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/mcc_front.sv
`default_nettype none
module mcc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_data,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_end_of_text,
    input  wire logic          i_q_full,
    output logic               o_job_push,
    output mcc_pkg::t_job      o_job
);

    logic       r_dir;
    logic [5:0] r_tok_pat;
    logic [2:0] r_tok_len;
    logic       r_tok_bad;
    logic       r_tok_slash;

    logic       n_pat_dash;
    logic [5:0] t1_pat;
    logic [2:0] t1_len;
    logic       t1_bad;
    logic       t1_slash;
    logic [5:0] f_pat;
    logic [2:0] f_len;
    logic       f_bad;
    logic       f_slash;
    logic       accept;
    logic       is_ws;
    logic       do_flush;
    logic [7:0] up_byte;
    logic [7:0] flush_ch;
    mcc_pkg::t_code enc;
    mcc_pkg::t_dec  dec;
    mcc_pkg::t_job  job;
    logic           job_valid;

    assign accept = i_push && !i_q_full;
    assign is_ws  = (i_in_byte == mcc_pkg::CH_SPACE) ||
                    (i_in_byte >= 8'h09 && i_in_byte <= 8'h0D);

    // token after taking this byte in
    always_comb begin
        n_pat_dash = (i_in_byte == mcc_pkg::CH_DASH) && (r_tok_len < mcc_pkg::MAX_SYMBOLS);
        t1_pat   = r_tok_pat;
        if (n_pat_dash) begin
            t1_pat[r_tok_len] = 1'b1;
        end
        t1_bad   = r_tok_bad ||
                   !((i_in_byte == mcc_pkg::CH_DOT) || (i_in_byte == mcc_pkg::CH_DASH));
        t1_slash = (r_tok_len == 3'd0) && (i_in_byte == mcc_pkg::CH_SLASH);
        t1_len   = (r_tok_len == mcc_pkg::LEN_SAT) ? r_tok_len : r_tok_len + 3'd1;
    end

    // whitespace closes the old token, the end flag closes the updated one
    always_comb begin
        do_flush = is_ws || i_end_of_text;
        if (is_ws) begin
            f_pat   = r_tok_pat;
            f_len   = r_tok_len;
            f_bad   = r_tok_bad;
            f_slash = r_tok_slash;
        end else begin
            f_pat   = t1_pat;
            f_len   = t1_len;
            f_bad   = t1_bad;
            f_slash = t1_slash;
        end
        dec = mcc_pkg::decode_code(f_len, f_pat);
        if (f_len == 3'd1 && f_slash) begin
            flush_ch = mcc_pkg::CH_SPACE;
        end else if (f_bad || f_len == mcc_pkg::LEN_SAT || !dec.found) begin
            flush_ch = mcc_pkg::CH_QMARK;
        end else begin
            flush_ch = dec.ch;
        end
    end

    always_comb begin
        up_byte = (i_in_byte >= mcc_pkg::CH_LOW_A && i_in_byte <= mcc_pkg::CH_LOW_Z) ?
                  i_in_byte - mcc_pkg::CASE_OFS : i_in_byte;
        enc = mcc_pkg::encode_char(up_byte);
        job = '{1'b0, 8'h00, 3'd0, 6'd0, 1'b0};
        if (!r_dir) begin
            job_valid = 1'b1;
            if (i_in_byte == mcc_pkg::CH_SPACE) begin
                job = '{1'b1, mcc_pkg::CH_SLASH, 3'd0, 6'd0, 1'b1};
            end else if (enc.found) begin
                job = '{1'b0, 8'h00, enc.len, enc.pat, 1'b1};
            end else begin
                job = '{1'b1, mcc_pkg::CH_QMARK, 3'd0, 6'd0, 1'b1};
            end
        end else begin
            job_valid = do_flush && (f_len != 3'd0);
            job = '{1'b1, flush_ch, 3'd0, 6'd0, 1'b0};
        end
    end

    assign o_job_push = accept && job_valid;
    assign o_job      = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= 1'b0;
            r_tok_pat   <= '0;
            r_tok_len   <= '0;
            r_tok_bad   <= 1'b0;
            r_tok_slash <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dir <= i_cfg_data;
            end
            if (accept && r_dir) begin
                if (do_flush) begin
                    r_tok_pat   <= '0;
                    r_tok_len   <= '0;
                    r_tok_bad   <= 1'b0;
                    r_tok_slash <= 1'b0;
                end else begin
                    r_tok_pat   <= t1_pat;
                    r_tok_len   <= t1_len;
                    r_tok_bad   <= t1_bad;
                    r_tok_slash <= t1_slash;
                end
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> !i_q_full) else $error("job pushed into full queue");
    a_pat_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tok_len <= 3'd5) |-> ((r_tok_pat >> r_tok_len) == 6'd0))
        else $error("token pattern has bits past its length");
    a_slash_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_slash |-> (r_tok_len == 3'd1 && r_tok_bad))
        else $error("slash flag on a token that is not a lone slash");

endmodule
`default_nettype wire

### sv/mcc_jobq.sv
`default_nettype none
module mcc_jobq #(
    parameter int DEPTH = mcc_pkg::JOBQ_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire mcc_pkg::t_job i_wr_job,
    input  wire logic          i_rd,
    output mcc_pkg::t_job      o_rd_job,
    output logic               o_full,
    output logic               o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    mcc_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full   = (r_count == FULL_CNT);
    assign o_empty  = (r_count == '0);
    assign o_rd_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT) else $error("job queue count overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty) else $error("job queue read while empty");
    a_ptr_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> (r_wr_ptr == r_rd_ptr)) else $error("empty queue with pointers apart");

endmodule
`default_nettype wire

### sv/mcc_back.sv
`default_nettype none
module mcc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_empty,
    input  wire mcc_pkg::t_job i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [7:0]         o_out_byte,
    output logic               o_run_last
);

    logic       r_busy;
    logic       r_lead;
    logic [7:0] r_lead_ch;
    logic [2:0] r_rem;
    logic [5:0] r_pat;
    logic       r_tail;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       out_free;
    logic       adv;
    logic       step_last;
    logic [7:0] step_byte;

    assign out_free = !r_out_valid || i_pop;
    assign adv      = r_busy && out_free;

    always_comb begin
        if (r_lead) begin
            step_byte = r_lead_ch;
            step_last = (r_rem == 3'd0) && !r_tail;
        end else if (r_rem != 3'd0) begin
            step_byte = r_pat[0] ? mcc_pkg::CH_DASH : mcc_pkg::CH_DOT;
            step_last = (r_rem == 3'd1) && !r_tail;
        end else begin
            step_byte = mcc_pkg::CH_SPACE;
            step_last = 1'b1;
        end
    end

    // next job loads in the cycle the current one sends its final byte
    assign o_job_pop = !i_job_empty && (!r_busy || (adv && step_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_lead      <= 1'b0;
            r_rem       <= '0;
            r_tail      <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_busy    <= 1'b1;
                r_lead    <= i_job.has_lead;
                r_lead_ch <= i_job.lead;
                r_rem     <= i_job.len;
                r_pat     <= i_job.pat;
                r_tail    <= i_job.has_tail;
            end else if (adv) begin
                if (step_last) begin
                    r_busy <= 1'b0;
                end
                if (r_lead) begin
                    r_lead <= 1'b0;
                end else if (r_rem != 3'd0) begin
                    r_rem <= r_rem - 3'd1;
                    r_pat <= r_pat >> 1;
                end else begin
                    r_tail <= 1'b0;
                end
            end
            if (out_free) begin
                r_out_valid <= adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= step_byte;
            r_out_last <= step_last;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_out_last;

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_lead || r_rem != 3'd0 || r_tail)) else $error("busy emitter with no work");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_pop && r_busy) |-> (adv && step_last)) else $error("job loaded over live job");
    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid) else $error("emitted byte not held in output register");

endmodule
`default_nettype wire

### sv/morse_code_codec.sv
// Morse code codec. With the direction register at 0 each accepted byte turns
// into Morse text ("/ " for a space, dots and dashes plus a space, or "? "); at 1
// Morse text is gathered into tokens and each closed token yields one character.
// run_last marks the final result byte of each input item. The emitter sends one
// result byte per cycle unless its output is held unpopped; a two-entry job queue
// between the classifying front end and the emitter lets input run ahead by up to
// two items. The user must write direction through i_cfg_we/i_cfg_data only while
// the block is idle; the block itself does not enforce it.
`default_nettype none
module morse_code_codec #(
    parameter int JOBQ_DEPTH = mcc_pkg::JOBQ_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_text,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last
);

    logic          q_full;
    logic          q_empty;
    logic          job_push;
    logic          job_pop;
    mcc_pkg::t_job wr_job;
    mcc_pkg::t_job rd_job;

    assign full = q_full;

    mcc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (q_full),
        .o_job_push    (job_push),
        .o_job         (wr_job)
    );

    mcc_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (job_push),
        .i_wr_job (wr_job),
        .i_rd     (job_pop),
        .o_rd_job (rd_job),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    mcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (q_empty),
        .i_job       (rd_job),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

endmodule
`default_nettype wire
